[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// A property checked on every rising clock edge outside reset.
`define ASSERT_SYNC(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// An implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// A next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_SYNC(label, clk, rstn, prop, msg)
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

[design/lpfr_pkg.sv]
// ----------------------------------------------------------------------------
// lpfr_pkg
// Types and constants of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

  localparam int FrameBufferBytes = 2048;
  // Width of the frame byte counters; any accepted count fits.
  localparam int CntW = $clog2(FrameBufferBytes);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CHECKSUM = 2'd1,
    STATUS_REMOTE   = 2'd2,
    STATUS_BAD_LEN  = 2'd3
  } frame_status_e;

  typedef struct packed {
    logic          is_payload;
    logic [7:0]    payload_byte;
    frame_status_e frame_status;
    logic [7:0]    remote_code;
    logic [10:0]   payload_count;
  } frx_result_t;

endpackage

`default_nettype wire

[design/lpfr_in_reg.sv]
// ----------------------------------------------------------------------------
// lpfr_in_reg
// Input register stage that holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  import lpfr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // The stage may refill in the same cycle its byte moves on.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

[design/lpfr_parser.sv]
// ----------------------------------------------------------------------------
// lpfr_parser
// Frame state and the single-pass decode of one byte into an optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output lpfr_pkg::frx_result_t res_o
);
  import lpfr_pkg::*;

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_LOW,
    PH_CODE,
    PH_BODY
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      count_high_q, count_high_d;
  logic [CntW-1:0] bytes_left_q, bytes_left_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      code_q, code_d;
  logic [CntW-1:0] seen_q, seen_d;

  logic [15:0]     len;
  logic            len_bad;
  logic [CntW-1:0] left_dec;
  logic [CntW+10:0] seen_ext;

  assign len      = {count_high_q, byte_i};
  assign len_bad  = (len < 16'd2) || ({1'b0, len} >= 17'(FrameBufferBytes - 2));
  assign left_dec = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : bytes_left_q;
  // Zero-extend before taking the low bits so narrow counters still fit.
  assign seen_ext = {11'd0, seen_q};

  always_comb begin
    phase_d      = phase_q;
    count_high_d = count_high_q;
    bytes_left_d = bytes_left_q;
    xor_d        = xor_q ^ byte_i;
    code_d       = code_q;
    seen_d       = seen_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    unique case (phase_q)
      PH_HIGH: begin
        count_high_d = byte_i;
        xor_d        = byte_i;
        phase_d      = PH_LOW;
      end
      PH_LOW: begin
        if (len_bad) begin
          phase_d            = PH_HIGH;
          bytes_left_d       = '0;
          res_valid_o        = 1'b1;
          res_o.frame_status = STATUS_BAD_LEN;
        end else begin
          bytes_left_d = len[CntW-1:0];
          seen_d       = '0;
          phase_d      = PH_CODE;
        end
      end
      PH_CODE: begin
        code_d       = byte_i;
        bytes_left_d = bytes_left_q - 1'b1;
        phase_d      = PH_BODY;
      end
      PH_BODY: begin
        bytes_left_d = left_dec;
        res_valid_o  = 1'b1;
        if (left_dec != '0) begin
          seen_d             = seen_q + 1'b1;
          res_o.is_payload   = 1'b1;
          res_o.payload_byte = byte_i;
        end else begin
          phase_d             = PH_HIGH;
          res_o.remote_code   = code_q;
          res_o.payload_count = seen_ext[10:0];
          // A bad checksum outranks a remote error code.
          priority if (xor_d != 8'd0) begin
            res_o.frame_status = STATUS_CHECKSUM;
          end else if (code_q != 8'd0) begin
            res_o.frame_status = STATUS_REMOTE;
          end else begin
            res_o.frame_status = STATUS_OK;
          end
        end
      end
      default: begin
        phase_d = PH_HIGH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HIGH;
      count_high_q <= '0;
      bytes_left_q <= '0;
      xor_q        <= '0;
      code_q       <= '0;
      seen_q       <= '0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      count_high_q <= count_high_d;
      bytes_left_q <= bytes_left_d;
      xor_q        <= xor_d;
      code_q       <= code_d;
      seen_q       <= seen_d;
    end
  end

endmodule

`default_nettype wire

[design/lpfr_out_reg.sv]
// ----------------------------------------------------------------------------
// lpfr_out_reg
// Result register that holds one request until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  lpfr_pkg::frx_result_t res_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lpfr_pkg::frx_result_t res_o
);
  import lpfr_pkg::*;

  logic        valid_q, valid_d;
  frx_result_t res_q;

  // Free when empty or when the held request leaves this cycle.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[design/length_prefixed_xor_frame_receiver.sv]
// A byte's result reaches the output via the input register, then the result register.
// Throughput: one byte per cycle while out_stall_i is low, set by the input and
// result registers around a single pass of counter and XOR update logic.
// Bytes that close no request (count, code) still pass the input register.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to waiting for the high count byte with all counters cleared.
// ----------------------------------------------------------------------------
// length_prefixed_xor_frame_receiver
// Receives length-prefixed frames, forwards payload and reports frame status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module length_prefixed_xor_frame_receiver (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_payload_o,
  output logic [7:0]             payload_byte_o,
  output logic [1:0]             frame_status_o,
  output logic [7:0]             remote_code_o,
  output logic [10:0]            payload_count_o
);
  import lpfr_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_free;
  logic        s1_go;
  logic        res_valid;
  frx_result_t res;
  frx_result_t out_res;

  assign s1_go = s1_valid && out_free;

  lpfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (s1_go),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  lpfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_go),
    .byte_i      (s1_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_go && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign is_payload_o    = out_res.is_payload;
  assign payload_byte_o  = out_res.payload_byte;
  assign frame_status_o  = out_res.frame_status;
  assign remote_code_o   = out_res.remote_code;
  assign payload_count_o = out_res.payload_count;

  `ASSERT_NEXT(a_s1_held, clk_i, rst_ni, s1_valid && !out_free, s1_valid,
    "buffered byte dropped while result register was blocked")
  `ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, in_stall_o, s1_valid && out_valid_o,
    "input stalled without a blocked byte behind it")
  `ASSERT_IMPLY(a_payload_clean, clk_i, rst_ni, out_valid_o && is_payload_o,
    (frame_status_o == STATUS_OK) && (payload_count_o == 11'd0),
    "payload request carries end-of-frame fields")
  `ASSERT_IMPLY(a_bad_len_clean, clk_i, rst_ni,
    out_valid_o && (frame_status_o == STATUS_BAD_LEN),
    !is_payload_o && (remote_code_o == 8'd0) && (payload_count_o == 11'd0),
    "bad length report carries frame fields")

endmodule

`default_nettype wire
